// File: rtl/four_phase_sample_accumulator_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the four phase sample accumulator
// Clocked concurrent assertion forms shared by the checker.
// ---------------------------------------------------------------------------
`ifndef FOUR_PHASE_SAMPLE_ACCUMULATOR_CORE_ASSERT_SVH
`define FOUR_PHASE_SAMPLE_ACCUMULATOR_CORE_ASSERT_SVH

// property must hold at every edge out of reset
`define FPSA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fpsa assertion failed");

// condition must never be seen out of reset
`define FPSA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `FPSA_ASSERT(lbl, clk, rstn, !(cond))

`endif

// File: rtl/fpsa_pkg.sv
// ---------------------------------------------------------------------------
// fpsa_pkg
// Types and constants of the four phase sample accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package fpsa_pkg;

  localparam int unsigned Log2Samples = 6;
  localparam logic [7:0]  SamplesInit = 8'((1 << Log2Samples) & 255);

  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CntW    = 16;
  localparam int unsigned BinCnt  = 4;
  localparam int unsigned BinW    = 2;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned OutUsedW = 66;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY  = 1'b0,
    CFG_STREAM = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SYNC     = 2'd0,
    PH_SYNC2    = 2'd1,
    PH_SAMPLING = 2'd2,
    PH_DONE     = 2'd3
  } phase_e;

  typedef struct packed {
    logic               done;
    logic [CntW-1:0]    resync_count;
    logic [CntW-1:0]    overload_count;
    logic [SampleW-1:0] echo_sample;
    logic               echo_valid;
    logic [SumW-1:0]    bin_sum;
    logic [BinW-1:0]    bin_index;
    logic               bin_valid;
    logic               resync_pulse;
    logic [1:0]         mode;
  } fpsa_res_t;

endpackage

`default_nettype wire

// File: rtl/fpsa_seq.sv
// ---------------------------------------------------------------------------
// fpsa_seq
// Measurement sequencer: phase state, counters and the four phase bins,
// updated once per item.
// ---------------------------------------------------------------------------
`default_nettype none

module fpsa_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         kind_i,
  input  wire logic [fpsa_pkg::SampleW-1:0] sample_i,
  input  wire logic                         tx_ready_i,
  input  wire logic [7:0]                   delay_i,
  input  wire logic                         stream_en_i,
  output fpsa_pkg::fpsa_res_t               res_o
);
  import fpsa_pkg::*;

  phase_e                phase_q, phase_d;
  logic [7:0]            skip_q, skip_d;
  logic [7:0]            left_q, left_d;
  logic [SumW-1:0]       sums_q [BinCnt];
  logic [SumW-1:0]       sums_d [BinCnt];
  logic [CntW-1:0]       drop_q, drop_d;
  logic [CntW-1:0]       rsc_q, rsc_d;
  logic [BinW-1:0]       bidx;
  logic [SumW-1:0]       sum_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      skip_q  <= '0;
      left_q  <= '0;
      drop_q  <= '0;
      rsc_q   <= '0;
      for (int i = 0; i < BinCnt; i++) sums_q[i] <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      left_q  <= left_d;
      drop_q  <= drop_d;
      rsc_q   <= rsc_d;
      for (int i = 0; i < BinCnt; i++) sums_q[i] <= sums_d[i];
    end
  end

  // first sample of a run lands in bin 0
  assign bidx    = BinW'(0) - left_q[BinW-1:0];
  assign sum_new = sums_q[bidx] + SumW'(sample_i);

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    left_d  = left_q;
    drop_d  = drop_q;
    rsc_d   = rsc_q;
    for (int i = 0; i < BinCnt; i++) sums_d[i] = sums_q[i];
    res_o   = '0;

    if (!kind_i) begin
      skip_d  = delay_i;
      left_d  = SamplesInit;
      phase_d = PH_SYNC;
    end else begin
      case (phase_q)
        PH_SYNC: begin
          phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_d = PH_SAMPLING;
          for (int i = 0; i < BinCnt; i++) sums_d[i] = '0;
          rsc_d = rsc_q + CntW'(1);
          res_o.resync_pulse = 1'b1;
        end
        PH_SAMPLING: begin
          if (left_q == '0) begin
            phase_d = PH_DONE;
          end else if (skip_q != '0) begin
            skip_d = skip_q - 8'd1;
          end else begin
            sums_d[bidx]    = sum_new;
            res_o.bin_valid = 1'b1;
            res_o.bin_index = bidx;
            res_o.bin_sum   = sum_new;
            if (stream_en_i) begin
              if (tx_ready_i) begin
                res_o.echo_valid  = 1'b1;
                res_o.echo_sample = sample_i;
              end else begin
                drop_d = drop_q + CntW'(1);
              end
            end
            left_d = left_q - 8'd1;
            if (left_q == 8'd1) phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    res_o.mode           = phase_d;
    res_o.overload_count = drop_d;
    res_o.resync_count   = rsc_d;
    res_o.done           = (phase_d == PH_DONE);
  end

endmodule

`default_nettype wire

// File: rtl/four_phase_sample_accumulator_core.sv
// ---------------------------------------------------------------------------
// four_phase_sample_accumulator_core
// Four bin phase accumulator for 10-bit converter samples with sync,
// delay and streaming echo.
// ---------------------------------------------------------------------------
//  channel   | dir | signals                       | payload
//  s_axis    | in  | tvalid tready tdata tuser     | sample, tx_ready / kind
//  m_axis    | out | tvalid tready tdata           | one result per item
//  cfg       | in  | cfg_we_i cfg_idx_i cfg_wdata_i| delay_samples, stream_enable
//
//  Two register stages: input register, then result register.
//  One item per cycle sustained while m_axis is not stalled.
//  Reset: phase done; counters, bins, valid flags, config zero; data regs not reset.
//  m_axis stall holds the result; s_axis keeps taking items until the
//  input register is also full.
// ---------------------------------------------------------------------------
`default_nettype none

module four_phase_sample_accumulator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [fpsa_pkg::InDataW-1:0]   s_axis_tdata,  // sample[9:0], tx_ready[10]
  input  wire logic                           s_axis_tuser,  // kind[0]
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // mode[1:0], resync_pulse[2], bin_valid[3], bin_index[5:4], bin_sum[21:6],
  // echo_valid[22], echo_sample[32:23], overload_count[48:33],
  // resync_count[64:49], done_res[65]
  output logic [fpsa_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [fpsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [fpsa_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fpsa_pkg::*;

  logic [7:0]          delay_q;
  logic                stream_q;
  logic                in_valid_q;
  logic                in_kind_q;
  logic [SampleW-1:0]  in_sample_q;
  logic                in_txr_q;
  logic                out_valid_q;
  fpsa_res_t           out_res_q;
  fpsa_res_t           res;
  logic                adv;
  logic                in_take;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= '0;
      stream_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY:  delay_q  <= cfg_wdata_i;
        CFG_STREAM: stream_q <= cfg_wdata_i[0];
        default:    delay_q  <= delay_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q   <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[SampleW-1:0];
      in_txr_q    <= s_axis_tdata[SampleW];
    end
    if (adv) out_res_q <= res;
  end

  fpsa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .kind_i      (in_kind_q),
    .sample_i    (in_sample_q),
    .tx_ready_i  (in_txr_q),
    .delay_i     (delay_q),
    .stream_en_i (stream_q),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_res_q};

endmodule

`default_nettype wire

// File: rtl/fpsa_checker.sv
// ---------------------------------------------------------------------------
// fpsa_checker
// Port-level checks of the four phase sample accumulator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "four_phase_sample_accumulator_core_assert.svh"

module fpsa_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic [fpsa_pkg::OutDataW-1:0]  m_axis_tdata
);
  import fpsa_pkg::*;

  fpsa_res_t res;
  logic      stall;
  logic      bin_stray;
  logic      rs_out;

  assign res       = fpsa_res_t'(m_axis_tdata[OutUsedW-1:0]);
  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign bin_stray = !res.bin_valid && (m_axis_tdata[21:4] != '0);
  assign rs_out    = m_axis_tvalid && res.resync_pulse;

  `FPSA_ASSERT(a_out_hold, clk_i, rst_ni, stall |=> $stable(m_axis_tdata))
  `FPSA_ASSERT(a_done_mode, clk_i, rst_ni, m_axis_tvalid |-> (res.done == (res.mode == PH_DONE)))
  `FPSA_ASSERT_NEVER(a_echo_no_bin, clk_i, rst_ni, m_axis_tvalid && res.echo_valid && !res.bin_valid)
  `FPSA_ASSERT_NEVER(a_idle_bin, clk_i, rst_ni, m_axis_tvalid && bin_stray)
  `FPSA_ASSERT(a_resync_mode, clk_i, rst_ni, rs_out |-> res.mode == PH_SAMPLING)

endmodule

bind four_phase_sample_accumulator_core fpsa_checker u_fpsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
